/* hdl/rclp_pkg.sv */
// Package for the relay command line parser: types, byte codes and defaults.
`timescale 1ns / 1ps

package rclp_pkg;

    localparam int SWITCH_COUNT_DEF   = 4;
    localparam int DIRECTED_COUNT_DEF = 4;

    localparam int CHAR_W  = 8;
    localparam int CHAN_W  = 4;
    localparam int VALUE_W = 32;

    // ASCII codes of the grammar
    localparam logic [CHAR_W-1:0] CH_S     = 8'h73;  // 's'
    localparam logic [CHAR_W-1:0] CH_D     = 8'h64;  // 'd'
    localparam logic [CHAR_W-1:0] CH_T     = 8'h74;  // 't'
    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;  // ':'
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;  // ' '
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [CHAR_W-1:0] DEC_BASE = 8'd10;

    typedef enum logic [2:0] {
        PH_SERVICE = 3'd0,
        PH_COLON   = 3'd1,
        PH_INST    = 3'd2,
        PH_SEP     = 3'd3,
        PH_T       = 3'd4,
        PH_SPACE   = 3'd5,
        PH_DIGITS  = 3'd6
    } t_phase;

    typedef struct packed {
        t_phase               phase;
        logic                 kind;
        logic [CHAN_W-1:0]    channel;
        logic                 timeout;
        logic [VALUE_W-1:0]   value;
        logic                 digit_seen;
        logic                 failed;
    } t_parse_state;

    typedef struct packed {
        logic                 ok;
        logic                 channel_kind;
        logic [CHAN_W-1:0]    channel;
        logic                 is_timeout;
        logic [VALUE_W-1:0]   value;
    } t_result;

    localparam t_parse_state STATE_RESET = '{
        phase:      PH_SERVICE,
        kind:       1'b0,
        channel:    '0,
        timeout:    1'b0,
        value:      '0,
        digit_seen: 1'b0,
        failed:     1'b0
    };

endpackage

/* hdl/rclp_if.sv */
// Valid/ready word channels for the relay command line parser.
`timescale 1ns / 1ps

interface rclp_in_if;
    logic                       valid;
    logic                       ready;
    logic [rclp_pkg::CHAR_W-1:0] char_in;
    logic                       is_last;

    modport source (output valid, output char_in, output is_last, input ready);
    modport sink   (input valid, input char_in, input is_last, output ready);
endinterface

interface rclp_out_if;
    logic                         valid;
    logic                         ready;
    logic                         ok;
    logic                         channel_kind;
    logic [rclp_pkg::CHAN_W-1:0]  channel;
    logic                         is_timeout;
    logic [rclp_pkg::VALUE_W-1:0] value;

    modport source (output valid, output ok, output channel_kind, output channel,
                    output is_timeout, output value, input ready);
    modport sink   (input valid, input ok, input channel_kind, input channel,
                    input is_timeout, input value, output ready);
endinterface

/* hdl/relay_command_line_parser.sv */
// Top level of the relay command line parser.
//
// Usage:
//   i_in carries one command-line byte per word (char_in) with is_last on
//   the final byte. o_out carries one result word per line, produced when
//   the byte marked is_last has been parsed: ok, channel_kind, channel,
//   is_timeout and value (all zero, ok=0 included, when the line is bad).
// Timing:
//   A byte is captured in an input register, parsed from there by the
//   step logic against the held parse state, and a line's result lands
//   in the output register, which raises o_out.valid. One byte per cycle
//   is accepted sustained unless a last byte waits on a held result; the
//   parse state update (v*10 + d adds) feeds back on r_state.
// Stall:
//   While a result waits in o_out, non-last bytes keep flowing; a further
//   last byte is held in the input register until the result is taken,
//   which then back-pressures i_in.ready.
// Reset:
//   i_rst_n (synchronous, low) empties both registers and returns the
//   parser to expecting a service byte.
`timescale 1ns / 1ps

module relay_command_line_parser #(
    parameter int SWITCH_COUNT   = rclp_pkg::SWITCH_COUNT_DEF,
    parameter int DIRECTED_COUNT = rclp_pkg::DIRECTED_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rclp_in_if.sink     i_in,
    rclp_out_if.source  o_out
);
    import rclp_pkg::*;

    // input register
    logic                r_in_valid;
    logic [CHAR_W-1:0]   r_char;
    logic                r_last;

    // parse state and result register
    t_parse_state        r_state;
    t_parse_state        n_state;
    t_result             n_result;
    t_result             r_result;
    logic                r_out_valid;

    logic                fire;

    // a last byte may only be parsed when the result slot is free or being taken
    assign fire       = r_in_valid && (!r_last || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || fire;

    rclp_step #(
        .SWITCH_COUNT   (SWITCH_COUNT),
        .DIRECTED_COUNT (DIRECTED_COUNT)
    ) u_step (
        .i_state  (r_state),
        .i_char   (r_char),
        .i_last   (r_last),
        .o_next   (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_char <= i_in.char_in;
            r_last <= i_in.is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (fire) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && r_last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && r_last) begin
            r_result <= n_result;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.ok           = r_result.ok;
    assign o_out.channel_kind = r_result.channel_kind;
    assign o_out.channel      = r_result.channel;
    assign o_out.is_timeout   = r_result.is_timeout;
    assign o_out.value        = r_result.value;

endmodule

/* hdl/rclp_step.sv */
// One parser step: next parse state and line result for one byte.
`timescale 1ns / 1ps

module rclp_step #(
    parameter int SWITCH_COUNT   = rclp_pkg::SWITCH_COUNT_DEF,
    parameter int DIRECTED_COUNT = rclp_pkg::DIRECTED_COUNT_DEF
) (
    input  rclp_pkg::t_parse_state             i_state,
    input  logic [rclp_pkg::CHAR_W-1:0]        i_char,
    input  logic                               i_last,
    output rclp_pkg::t_parse_state             o_next,
    output rclp_pkg::t_result                  o_result
);
    import rclp_pkg::*;

    localparam logic [CHAN_W-1:0] SW_LIM  = CHAN_W'(SWITCH_COUNT);
    localparam logic [CHAN_W-1:0] DIR_LIM = CHAN_W'(DIRECTED_COUNT);

    logic [CHAR_W-1:0]  digit;
    logic               is_digit;
    logic [CHAN_W-1:0]  limit;
    logic               byte_bad;
    t_phase             n_phase;
    t_parse_state       upd;
    logic               good;

    assign digit    = i_char - CH_ZERO;
    assign is_digit = (digit < DEC_BASE);
    assign limit    = i_state.kind ? DIR_LIM : SW_LIM;

    // next phase and grammar check
    always_comb begin
        n_phase  = i_state.phase;
        byte_bad = 1'b0;
        unique case (i_state.phase)
            PH_SERVICE: begin
                if (i_char == CH_S || i_char == CH_D) n_phase = PH_COLON;
                else byte_bad = 1'b1;
            end
            PH_COLON: begin
                if (i_char == CH_COLON) n_phase = PH_INST;
                else byte_bad = 1'b1;
            end
            PH_INST: begin
                if (is_digit && digit[CHAN_W-1:0] < limit) n_phase = PH_SEP;
                else byte_bad = 1'b1;
            end
            PH_SEP: begin
                if (i_char == CH_COLON) n_phase = PH_T;
                else if (i_char == CH_SPACE) n_phase = PH_DIGITS;
                else byte_bad = 1'b1;
            end
            PH_T: begin
                if (i_char == CH_T) n_phase = PH_SPACE;
                else byte_bad = 1'b1;
            end
            PH_SPACE: begin
                if (i_char == CH_SPACE) n_phase = PH_DIGITS;
                else byte_bad = 1'b1;
            end
            PH_DIGITS: begin
                if (!is_digit) byte_bad = 1'b1;
            end
            default: byte_bad = 1'b1;
        endcase
    end

    // data fields; all frozen once the line has failed
    always_comb begin
        upd = i_state;
        if (!i_state.failed) begin
            upd.phase = n_phase;
            if (byte_bad) begin
                upd.failed = 1'b1;
            end else begin
                case (i_state.phase)
                    PH_SERVICE: upd.kind    = (i_char == CH_D);
                    PH_INST:    upd.channel = digit[CHAN_W-1:0];
                    PH_SEP:     upd.timeout = (i_char == CH_COLON);
                    PH_DIGITS: begin
                        // v*10 + d as shifts and two adds
                        upd.value = (i_state.value << 3) + (i_state.value << 1)
                                  + VALUE_W'(digit);
                        upd.digit_seen = 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign good   = !upd.failed && upd.phase == PH_DIGITS && upd.digit_seen;
    assign o_next = i_last ? STATE_RESET : upd;

    always_comb begin
        o_result = '0;
        if (good) begin
            o_result.ok           = 1'b1;
            o_result.channel_kind = upd.kind;
            o_result.channel      = upd.channel;
            o_result.is_timeout   = upd.timeout;
            o_result.value        = upd.value;
        end
    end

endmodule
